// ----- hdl/srti_pkg.sv -----
// Shared types and constants for the step response tangent identification block.
package srti_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GAIN_DIV,
      ST_MUL,
      ST_DEAD_DIV,
      ST_TL_DIV,
      ST_FINISH,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_GAIN,
      PH_DEAD,
      PH_TL
   } phase_type;

   typedef struct packed {
      logic sample_take;
      logic gain_start;
      logic mul_start;
      logic dead_start;
      logic tl_start;
      logic finish;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic need_final;
      logic need_tangent;
   } stat_type;

   localparam int DivWidth = 64;
   localparam logic [1:0] StatusFound    = 2'd0;
   localparam logic [1:0] StatusShort    = 2'd1;
   localparam logic [1:0] StatusNoSlope  = 2'd2;
   localparam logic [39:0] Q40Max        = 40'hFF_FFFF_FFFF;
   localparam logic [39:0] TauOne        = 40'd256;

endpackage

// ----- hdl/srti_div.sv -----
// Iterative restoring divider, one quotient bit a cycle, floor or truncating signed.
module srti_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [63:0]   numer,
   input  logic signed [63:0]   denom,
   input  logic                 floor_mode,
   output logic                 done,
   output logic signed [63:0]   quot
);
   logic [63:0] rem_ff, rem_in, q_ff, q_in, d_ff, d_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, neg_ff, neg_in, fl_ff, fl_in, done_ff, done_in;
   logic [64:0] trial;
   logic [63:0] sh;
   logic [63:0] mag;

   always_comb begin
      rem_in = rem_ff; q_in = q_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; neg_in = neg_ff; fl_in = fl_ff; done_in = 1'b0;
      sh = {rem_ff[62:0], q_ff[63]};
      trial = {1'b0, sh} - {1'b0, d_ff};
      if (start) begin
         rem_in = '0;
         q_in = numer[63] ? 64'(-numer) : numer;
         d_in = denom[63] ? 64'(-denom) : denom;
         neg_in = numer[63] ^ denom[63];
         fl_in = floor_mode;
         cnt_in = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = sh;
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in; q_ff <= q_in; d_ff <= d_in; cnt_ff <= cnt_in;
      neg_ff <= neg_in; fl_ff <= fl_in;
   end

   assign mag = (fl_ff && neg_ff && rem_ff != '0) ? q_ff + 64'd1 : q_ff;
   assign quot = neg_ff ? 64'(-mag) : mag;
   assign done = done_ff;
endmodule

// ----- hdl/srti_datapath.sv -----
// Datapath: sample window, slope search, gain and tangent arithmetic, result register.
module srti_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  srti_pkg::cmd_type    cmd,
   output srti_pkg::stat_type   stat,
   input  logic                 csr_valid,
   input  logic signed [15:0]   csr_step_size,
   input  logic [31:0]          req_sample_time,
   input  logic signed [15:0]   req_sample_value,
   input  logic                 req_last_sample,
   output logic signed [31:0]   rsp_gain,
   output logic [39:0]          rsp_dead_time,
   output logic [39:0]          rsp_time_constant,
   output logic [1:0]           rsp_status,
   output logic                 rsp_saturated
);
   logic signed [15:0] step_ff;
   logic [1:0]  cnt_ff;
   logic signed [15:0] init_ff, wv0_ff, wv1_ff, iv_ff, lastv_ff;
   logic [31:0] wt0_ff, wt1_ff, it_ff;
   logic signed [17:0] brise_ff;
   logic signed [33:0] bspan_ff;
   logic found_ff, short_ff;
   logic signed [17:0] rise;
   logic signed [33:0] span;
   logic signed [51:0] lhs, rhs;
   logic better;
   logic signed [63:0] tir_ff, d1s_ff, d2s_ff, lq_ff;
   logic signed [16:0] diff;
   logic signed [16:0] gdiff;
   logic signed [63:0] dnum, dden;
   logic dfloor, dstart, ddone;
   logic signed [63:0] dq;
   logic signed [63:0] lqc, tau;
   logic signed [31:0] gain_r;
   logic gsat;
   srti_pkg::phase_type phase_ff;
   logic signed [63:0] gq_ff, tl_ff;

   assign rise = 18'(req_sample_value) - 18'(wv0_ff);
   assign span = {2'b00, req_sample_time} - {2'b00, wt0_ff};
   assign lhs = 52'(rise) * 52'(bspan_ff);
   assign rhs = 52'(brise_ff) * 52'(span);
   assign better = cnt_ff >= 2'd2 && req_sample_time > wt0_ff && lhs > rhs;
   assign diff = 17'(lastv_ff) - 17'(init_ff);
   assign gdiff = 17'(req_sample_value) - 17'(init_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 16'sd1;
      end else if (csr_valid) begin
         step_ff <= csr_step_size;
      end
      if (reset || cmd.clear) begin
         cnt_ff <= '0; init_ff <= '0; wv0_ff <= '0; wv1_ff <= '0;
         wt0_ff <= '0; wt1_ff <= '0; brise_ff <= '0; bspan_ff <= 34'sd1;
         it_ff <= '0; iv_ff <= '0; found_ff <= 1'b0;
      end else if (cmd.sample_take) begin
         if (cnt_ff == 2'd0) init_ff <= req_sample_value;
         if (better) begin
            brise_ff <= rise; bspan_ff <= span;
            it_ff <= wt1_ff; iv_ff <= wv1_ff; found_ff <= 1'b1;
         end
         wt0_ff <= wt1_ff; wv0_ff <= wv1_ff;
         wt1_ff <= req_sample_time; wv1_ff <= req_sample_value;
         if (cnt_ff != 2'd3) cnt_ff <= cnt_ff + 2'd1;
      end
      if (cmd.sample_take) begin
         short_ff <= cnt_ff < 2'd2;
         lastv_ff <= req_sample_value;
      end
      if (cmd.mul_start) begin
         tir_ff <= 64'({32'd0, it_ff}) * 64'(brise_ff);
         d1s_ff <= 64'(17'(iv_ff) - 17'(init_ff)) * 64'(bspan_ff);
         d2s_ff <= 64'(17'(lastv_ff) - 17'(iv_ff)) * 64'(bspan_ff);
      end
   end

   // The gain division starts on the edge that takes the last sample, so its
   // numerator is formed from the incoming sample rather than the stored one.
   always_comb begin
      dstart = cmd.gain_start || cmd.dead_start || cmd.tl_start;
      dfloor = !cmd.gain_start;
      dden = 64'(brise_ff);
      dnum = (tir_ff - d1s_ff) <<< 8;
      if (cmd.gain_start) begin
         dnum = 64'(gdiff) <<< 16;
         dden = 64'(step_ff);
      end else if (cmd.tl_start) begin
         dnum = (tir_ff + d2s_ff) <<< 8;
      end
   end

   srti_div u_div (
      .clock(clock), .reset(reset), .start(dstart), .numer(dnum), .denom(dden),
      .floor_mode(dfloor), .done(ddone), .quot(dq)
   );

   always_ff @(posedge clock) begin
      if (reset) phase_ff <= srti_pkg::PH_GAIN;
      else if (cmd.gain_start) phase_ff <= srti_pkg::PH_GAIN;
      else if (cmd.dead_start) phase_ff <= srti_pkg::PH_DEAD;
      else if (cmd.tl_start) phase_ff <= srti_pkg::PH_TL;
   end

   always_ff @(posedge clock) begin
      if (ddone) begin
         case (phase_ff)
            srti_pkg::PH_GAIN: gq_ff <= dq;
            srti_pkg::PH_DEAD: lq_ff <= dq;
            default: tl_ff <= dq;
         endcase
      end
   end

   always_comb begin
      gsat = 1'b0;
      if (step_ff == 16'sd0) begin
         gsat = 1'b1;
         gain_r = diff > 0 ? 32'sh7FFF_FFFF : (diff < 0 ? 32'sh8000_0000 : 32'sd0);
      end else if (gq_ff > 64'sh7FFF_FFFF) begin
         gain_r = 32'sh7FFF_FFFF; gsat = 1'b1;
      end else if (gq_ff < -64'sh8000_0000) begin
         gain_r = 32'sh8000_0000; gsat = 1'b1;
      end else begin
         gain_r = gq_ff[31:0];
      end
      lqc = lq_ff[63] ? 64'sd0 : lq_ff;
      tau = tl_ff - lqc;
      if (tau <= 0) tau = 64'sd256;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (short_ff) begin
            rsp_gain <= '0; rsp_dead_time <= '0; rsp_time_constant <= '0;
            rsp_status <= srti_pkg::StatusShort; rsp_saturated <= 1'b0;
         end else if (!found_ff) begin
            rsp_gain <= gain_r; rsp_dead_time <= '0;
            rsp_time_constant <= srti_pkg::TauOne;
            rsp_status <= srti_pkg::StatusNoSlope; rsp_saturated <= gsat;
         end else begin
            rsp_gain <= gain_r;
            rsp_dead_time <= lqc > 64'(srti_pkg::Q40Max) ? srti_pkg::Q40Max : lqc[39:0];
            rsp_time_constant <= tau > 64'(srti_pkg::Q40Max) ? srti_pkg::Q40Max : tau[39:0];
            rsp_status <= srti_pkg::StatusFound;
            rsp_saturated <= gsat || lqc > 64'(srti_pkg::Q40Max)
                             || tau > 64'(srti_pkg::Q40Max);
         end
      end
   end

   assign stat.div_done = ddone;
   assign stat.need_final = req_last_sample;
   assign stat.need_tangent = found_ff;
endmodule

// ----- hdl/srti_ctrl.sv -----
// Controller state machine sequencing sample intake, divisions and result hand-off.
module srti_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  srti_pkg::stat_type   stat,
   output srti_pkg::cmd_type    cmd
);
   srti_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srti_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         srti_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.sample_take = 1'b1;
               if (stat.need_final) begin
                  cmd.gain_start = 1'b1;
                  state_in = srti_pkg::ST_GAIN_DIV;
               end
            end
         end
         srti_pkg::ST_GAIN_DIV: begin
            if (stat.div_done) begin
               if (stat.need_tangent) begin
                  cmd.mul_start = 1'b1;
                  state_in = srti_pkg::ST_MUL;
               end else begin
                  state_in = srti_pkg::ST_FINISH;
               end
            end
         end
         srti_pkg::ST_MUL: begin
            cmd.dead_start = 1'b1;
            state_in = srti_pkg::ST_DEAD_DIV;
         end
         srti_pkg::ST_DEAD_DIV: begin
            if (stat.div_done) begin
               cmd.tl_start = 1'b1;
               state_in = srti_pkg::ST_TL_DIV;
            end
         end
         srti_pkg::ST_TL_DIV: begin
            if (stat.div_done) state_in = srti_pkg::ST_FINISH;
         end
         srti_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
            cmd.clear = 1'b1;
            state_in = srti_pkg::ST_OUT;
         end
         srti_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = srti_pkg::ST_IDLE;
         end
         default: state_in = srti_pkg::ST_IDLE;
      endcase
   end
endmodule

// ----- hdl/step_response_tangent_identify_top.sv -----
// Top level of the step response tangent identification block.
// Samples of a step-response run enter on the req_ channel, one item per
// cycle while no run is being closed. Each item carries a timestamp, a
// signed value and a last flag. A sample that is not last causes no result.
// The last sample of a run starts the closing sequence: a gain division,
// and where a tangent was found a multiply step and two further tangent
// divisions on the same shared serial divider. rsp_valid rises once the
// last division and the finish state are done, and the result item waits
// there while the receiver stalls; no new sample is taken until it has
// been delivered, and the next sample can be taken in the cycle after that.
// The step size register is written through the csr_ channel, which is
// always ready. Reset returns the step size to one and clears the run state.
module step_response_tangent_identify_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic signed [15:0]   csr_step_size,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [31:0]          req_sample_time,
   input  logic signed [15:0]   req_sample_value,
   input  logic                 req_last_sample,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [31:0]   rsp_gain,
   output logic [39:0]          rsp_dead_time,
   output logic [39:0]          rsp_time_constant,
   output logic [1:0]           rsp_status,
   output logic                 rsp_saturated
);
   srti_pkg::cmd_type  cmd;
   srti_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   srti_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .stat(stat), .cmd(cmd)
   );

   srti_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .csr_valid(csr_valid), .csr_step_size(csr_step_size),
      .req_sample_time(req_sample_time), .req_sample_value(req_sample_value),
      .req_last_sample(req_last_sample), .rsp_gain(rsp_gain),
      .rsp_dead_time(rsp_dead_time), .rsp_time_constant(rsp_time_constant),
      .rsp_status(rsp_status), .rsp_saturated(rsp_saturated)
   );
endmodule

// ----- hdl/srti_checker.sv -----
// Port-level checker for the step response tangent identification block.
module srti_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last_sample,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [39:0] rsp_time_constant
);
   a_no_take_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("sample taken while result pending");
   a_last_stops: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_sample |=> !req_ready)
      else $error("intake continued after last sample");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3) else $error("bad status");
   a_tau_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != srti_pkg::StatusShort |-> rsp_time_constant != '0)
      else $error("zero time constant");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped");
endmodule

bind step_response_tangent_identify_top srti_checker u_srti_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_last_sample(req_last_sample), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_status(rsp_status), .rsp_time_constant(rsp_time_constant)
);
